### rtl/core/rtpgr_pkg.sv
// Package for the RTP sequence gap resend tracker.
// Holds widths, codes, controller states and the command/status structs.
// No dependencies; every other file imports it.
`default_nettype none

package rtpgr_pkg;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int SEQ_W      = 16;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 7;
    localparam int DROP_W     = 32;
    localparam int INTERVAL_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_US  = 1'd1;

    localparam logic [INTERVAL_W-1:0] RETRY_US_RESET = 24'd250000;

    localparam int WINDOW_BITS_DEF = 64;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_REGULAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESEND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SLIDE,
        ST_SLIDE2,
        ST_RETRY,
        ST_RETRY2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;        // capture the input beat
        logic eval;         // classify the item and update the window
        logic slide_apply;  // shift the window past leading received entries
        logic find_zero;    // search the first clear mask bit instead of set
        logic retry_start;  // register the request age
        logic retry_apply;  // issue the repeat request if due
        logic load_out;     // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic go_slide;
        logic go_retry;
        logic mask_nz;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### rtl/core/rtpgr_pkt_if.sv
// Input channel of the RTP gap tracker: valid/ready plus one packet or tick.
// Depends on rtpgr_pkg.
`default_nettype none

interface rtpgr_pkt_if import rtpgr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] now_us;

    modport source (output valid, output mode, output seq, output now_us, input ready);
    modport sink   (input valid, input mode, input seq, input now_us, output ready);
endinterface

`default_nettype wire

### rtl/core/rtpgr_res_if.sv
// Result channel of the RTP gap tracker: valid/ready plus one result beat.
// Depends on rtpgr_pkg.
`default_nettype none

interface rtpgr_res_if import rtpgr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              nack_valid;
    logic [SEQ_W-1:0]  nack_first_seq;
    logic [CNT_W-1:0]  nack_count;
    logic [DROP_W-1:0] dropped_total;

    modport source (
        output valid, output accepted, output nack_valid, output nack_first_seq,
        output nack_count, output dropped_total, input ready
    );
    modport sink (
        input valid, input accepted, input nack_valid, input nack_first_seq,
        input nack_count, input dropped_total, output ready
    );
endinterface

`default_nettype wire

### rtl/core/rtpgr_lsb_find.sv
// Two-step lowest-set-bit finder over the missing mask (byte groups, then groups).
// Depends on rtpgr_pkg. Result is valid in the cycle after the vector is presented.
`default_nettype none

module rtpgr_lsb_find import rtpgr_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic [WINDOW_BITS-1:0]             i_vec,
    output logic      [$clog2(WINDOW_BITS+1)-1:0]   o_idx
);
    localparam int GROUPS = (WINDOW_BITS + 7) / 8;
    localparam int PAD_W  = GROUPS * 8;
    localparam int CW     = $clog2(WINDOW_BITS + 1);

    logic [PAD_W-1:0]  w_pad;
    logic [GROUPS-1:0] n_nz, r_nz;
    logic [2:0]        n_loc [GROUPS];
    logic [2:0]        r_loc [GROUPS];

    // Pad with ones above the window so a full run stops at WINDOW_BITS.
    always_comb begin
        w_pad = '1;
        w_pad[WINDOW_BITS-1:0] = i_vec;
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_nz[g]  = |w_pad[g*8 +: 8];
            n_loc[g] = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (w_pad[g*8 + b]) begin
                    n_loc[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nz  <= n_nz;
        r_loc <= n_loc;
    end

    always_comb begin
        o_idx = CW'(WINDOW_BITS);
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (r_nz[g]) begin
                o_idx = CW'(g * 8) + CW'(r_loc[g]);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/rtpgr_ctrl.sv
// Controller of the RTP gap tracker: sequences evaluate, slide, retry, output.
// Depends on rtpgr_pkg; drives the datapath through t_cmd, reads t_stat.
`default_nettype none

module rtpgr_ctrl import rtpgr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.go_slide)      n_state = ST_SLIDE;
                else if (i_stat.go_retry) n_state = ST_RETRY;
                else                      n_state = ST_DONE;
            end
            ST_SLIDE:  n_state = ST_SLIDE2;
            ST_SLIDE2: n_state = ST_RETRY;
            ST_RETRY: begin
                n_state = i_stat.mask_nz ? ST_RETRY2 : ST_DONE;
            end
            ST_RETRY2: n_state = ST_DONE;
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = i_in_valid ? ST_EVAL : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EVAL:   o_cmd.eval = 1'b1;
            ST_SLIDE:  o_cmd.find_zero = 1'b0;
            ST_SLIDE2: o_cmd.slide_apply = 1'b1;
            ST_RETRY: begin
                o_cmd.find_zero   = 1'b1;
                o_cmd.retry_start = 1'b1;
            end
            ST_RETRY2: o_cmd.retry_apply = 1'b1;
            ST_DONE: begin
                o_cmd.load_out = i_stat.out_free;
                o_in_ready     = i_stat.out_free;
                o_cmd.latch    = i_stat.out_free && i_in_valid;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/rtpgr_datapath.sv
// Datapath of the RTP gap tracker: sequence state, missing window, timers,
// config registers and the output register. Depends on rtpgr_pkg, rtpgr_lsb_find.
`default_nettype none

module rtpgr_datapath import rtpgr_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [SEQ_W-1:0]      i_seq,
    input  wire logic [TIME_W-1:0]     i_now_us,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_accepted,
    output logic                       o_nack_valid,
    output logic [SEQ_W-1:0]           o_nack_first_seq,
    output logic [CNT_W-1:0]           o_nack_count,
    output logic [DROP_W-1:0]          o_dropped_total
);
    localparam int W   = WINDOW_BITS;
    localparam int IXW = $clog2(WINDOW_BITS);
    localparam int CW  = $clog2(WINDOW_BITS + 1);
    localparam logic [SEQ_W-1:0] W_SEQ = SEQ_W'(WINDOW_BITS);

    // Config
    logic                  r_en;
    logic [INTERVAL_W-1:0] r_interval;

    // Tracking state
    logic              r_seen;
    logic [SEQ_W-1:0]  r_last, r_base;
    logic [W-1:0]      r_mask;
    logic [TIME_W-1:0] r_lrt;
    logic [DROP_W-1:0] r_drop;

    // Item and result
    logic [MODE_W-1:0] r_mode;
    logic [SEQ_W-1:0]  r_seq;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W:0]   r_age;
    logic              r_acc, r_nv;
    logic [SEQ_W-1:0]  r_nfirst;
    logic [CNT_W-1:0]  r_ncnt;

    // Output register
    logic              r_ov;
    logic              r_o_acc, r_o_nv;
    logic [SEQ_W-1:0]  r_o_first;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [DROP_W-1:0] r_o_drop;

    logic [CW-1:0] w_idx;

    rtpgr_lsb_find #(.WINDOW_BITS(WINDOW_BITS)) u_find (
        .i_clk (i_clk),
        .i_vec (i_cmd.find_zero ? ~r_mask : r_mask),
        .o_idx (w_idx)
    );

    // Evaluate decode
    logic [SEQ_W-1:0] w_expected, w_d, w_off, w_off2;
    logic [W-1:0]     w_ones, w_cleared, w_mask_add;
    logic             w_mask_nz, w_hit, w_fits, w_in_win;
    logic             e_acc, e_last, e_add, e_req, e_clear, e_retry;

    always_comb begin
        w_expected = r_last + SEQ_W'(1);
        w_d        = r_seq - w_expected;
        w_off      = r_seq - r_base;
        w_off2     = w_expected - r_base;
        w_mask_nz  = |r_mask;
        w_in_win   = (w_d <= W_SEQ);
        w_hit      = w_mask_nz && (w_off < W_SEQ) && r_mask[w_off[IXW-1:0]];
        w_cleared  = r_mask & ~(W'(1) << w_off[IXW-1:0]);
        w_ones     = ~({W{1'b1}} << w_d[CW-1:0]);
        w_fits     = w_mask_nz && (w_off2 < W_SEQ)
                     && (({1'b0, w_off2} + {1'b0, w_d}) <= (SEQ_W + 1)'(WINDOW_BITS));
        w_mask_add = w_fits ? (r_mask | (w_ones << w_off2[IXW-1:0])) : w_ones;

        e_acc   = 1'b0;
        e_last  = 1'b0;
        e_add   = 1'b0;
        e_req   = 1'b0;
        e_clear = 1'b0;
        e_retry = 1'b0;
        case (r_mode)
            MODE_REGULAR: begin
                if (!r_seen || w_d == '0) begin
                    e_acc   = 1'b1;
                    e_last  = 1'b1;
                    e_retry = 1'b1;
                end else if (!w_d[SEQ_W-1]) begin
                    // forward gap
                    e_acc   = 1'b1;
                    e_last  = 1'b1;
                    e_add   = w_in_win;
                    e_req   = w_in_win && r_en;
                    e_retry = !(w_in_win && r_en);
                end else begin
                    e_clear = 1'b1;
                end
            end
            MODE_RESEND: e_clear = 1'b1;
            MODE_TICK:   e_retry = 1'b1;
            default:     e_acc = 1'b0;
        endcase
        if (e_clear) begin
            e_acc = w_hit;
        end
    end

    assign o_stat.go_slide = e_clear && w_hit && (w_cleared != '0);
    assign o_stat.go_retry = e_retry;
    assign o_stat.mask_nz  = w_mask_nz;
    assign o_stat.out_free = !r_ov || i_out_ready;

    logic w_due;
    assign w_due = (r_lrt == '0)
                   || (!r_age[TIME_W] && r_age[TIME_W-1:0] >= TIME_W'(r_interval));

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en       <= 1'b0;
            r_interval <= RETRY_US_RESET;
            r_seen     <= 1'b0;
            r_last     <= '0;
            r_base     <= '0;
            r_mask     <= '0;
            r_lrt      <= '0;
            r_drop     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RESEND_EN: r_en       <= i_cfg_data[0];
                    CFG_RETRY_US:  r_interval <= i_cfg_data[INTERVAL_W-1:0];
                endcase
            end
            if (i_cmd.eval) begin
                if (e_last) begin
                    r_seen <= 1'b1;
                    r_last <= r_seq;
                end
                if (e_add) begin
                    r_drop <= r_drop + DROP_W'(w_d);
                    r_mask <= w_mask_add;
                    if (!w_fits) r_base <= w_expected;
                end
                if (e_req) begin
                    r_lrt <= r_now;
                end
                if (e_clear && w_hit) begin
                    r_mask <= w_cleared;
                    if (w_cleared == '0) r_lrt <= '0;
                end
            end
            if (i_cmd.slide_apply) begin
                r_mask <= r_mask >> w_idx;
                r_base <= r_base + SEQ_W'(w_idx);
            end
            if (i_cmd.retry_apply && w_due && r_en) begin
                r_lrt <= r_now;
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_seq  <= i_seq;
            r_now  <= i_now_us;
        end
        if (i_cmd.eval) begin
            r_acc    <= e_acc;
            r_nv     <= e_req;
            r_nfirst <= e_req ? w_expected : '0;
            r_ncnt   <= e_req ? CNT_W'(w_d[CW-1:0]) : '0;
        end
        if (i_cmd.retry_start) begin
            r_age <= {1'b0, r_now} - {1'b0, r_lrt};
        end
        if (i_cmd.retry_apply && w_due && r_en) begin
            r_nv     <= 1'b1;
            r_nfirst <= r_base;
            r_ncnt   <= CNT_W'(w_idx);
        end
        if (i_cmd.load_out) begin
            r_o_acc   <= r_acc;
            r_o_nv    <= r_nv;
            r_o_first <= r_nfirst;
            r_o_cnt   <= r_ncnt;
            r_o_drop  <= r_drop;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_accepted       = r_o_acc;
    assign o_nack_valid     = r_o_nv;
    assign o_nack_first_seq = r_o_first;
    assign o_nack_count     = r_o_cnt;
    assign o_dropped_total  = r_o_drop;

endmodule

`default_nettype wire

### rtl/core/rtp_sequence_gap_resend_tracker.sv
// RTP sequence gap resend tracker, top level.
// Depends on rtpgr_pkg, rtpgr_pkt_if, rtpgr_res_if, rtpgr_ctrl, rtpgr_datapath.
//
// i_pkt carries one beat per RTP packet or timeout tick: mode (regular,
// retransmitted, tick), the 16-bit sequence number and the time in microseconds.
// o_res returns exactly one beat per input beat, in order: accepted flag,
// optional NACK (first sequence, run length) and the running drop counter.
// Both channels use valid/ready; a beat moves when both are high. The config
// port (i_cfg_we, i_cfg_idx, i_cfg_data) writes resend_enable (index 0) and
// retry_interval_us (index 1); write only while the block is idle.
//
// After acceptance an item steps through evaluate, retry age, retry apply and
// load into the output register; retry apply is skipped when the retry check
// finds the window empty, slide steps precede the retry age when a cleared hole
// makes the window slide, and no retry steps run when no retry check follows.
// The next beat is taken in the load cycle, not before the previous item loads.
// Reset (synchronous, active low) clears the tracking state, the drop counter
// and the config registers to their defaults, and empties the output register.
// On a receiver stall the result holds in the output register; the next item
// is still taken and processed, then waits until the slot frees.
`default_nettype none

module rtp_sequence_gap_resend_tracker import rtpgr_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rtpgr_pkt_if.sink                  i_pkt,
    rtpgr_res_if.source                o_res
);
    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: walks each item through evaluate / slide / retry / output.
    rtpgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .o_in_ready (i_pkt.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Window, counters, timers and the output register.
    rtpgr_datapath #(.WINDOW_BITS(WINDOW_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_pkt.mode),
        .i_seq            (i_pkt.seq),
        .i_now_us         (i_pkt.now_us),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_accepted       (o_res.accepted),
        .o_nack_valid     (o_res.nack_valid),
        .o_nack_first_seq (o_res.nack_first_seq),
        .o_nack_count     (o_res.nack_count),
        .o_dropped_total  (o_res.dropped_total)
    );

endmodule

`default_nettype wire
